// File: hw/rtl/configurable_branch_predictor_macros.svh
// assertion macros for the configurable branch predictor checker
// expects clk and rst_n in the scope of use
`ifndef CONFIGURABLE_BRANCH_PREDICTOR_MACROS_SVH
`define CONFIGURABLE_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication
`define CBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbp check failed");

// next-cycle implication
`define CBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbp check failed");

`endif

// File: hw/rtl/cbp_pkg.sv
// shared types and codes for the configurable branch predictor
// no dependencies
package cbp_pkg;

  typedef logic [1:0] ctr_t;
  typedef logic [2:0] mode_t;

  localparam mode_t MODE_NONE    = 3'd0;
  localparam mode_t MODE_PERFECT = 3'd1;
  localparam mode_t MODE_NT      = 3'd2;
  localparam mode_t MODE_T       = 3'd3;
  localparam mode_t MODE_ONE     = 3'd4;
  localparam mode_t MODE_TWO     = 3'd5;
  localparam mode_t MODE_GSHARE  = 3'd6;

  localparam mode_t       MODE_RESET = MODE_GSHARE;
  localparam logic [4:0]  HB_RESET   = 5'd12;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_HIST = 1'b1;

  localparam ctr_t CTR_MAX = 2'd3;
  localparam ctr_t CTR_MIN = 2'd0;

  function automatic ctr_t init_ctr(mode_t m);
    ctr_t v;
    unique case (m)
      MODE_ONE, MODE_GSHARE: v = 2'd1;
      MODE_TWO:              v = 2'd2;
      default:               v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/cbp_table.sv
// counter table memory: one write port, one registered read port
// depends on cbp_pkg
module cbp_table #(
  parameter int ENTRIES = 4096,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cbp_pkg::ctr_t wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output cbp_pkg::ctr_t rd_data
);
  import cbp_pkg::*;

  ctr_t mem [ENTRIES];
  ctr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/configurable_branch_predictor.sv
// top level of the configurable branch predictor
// depends on cbp_pkg and cbp_table
//
// For each item (a resolved branch), the accept cycle issues the counter
// table read, and the next cycle gets the counter, forms the prediction, writes the
// trained counter back and loads the output register; the single table memory with
// its registered read is why in_stall is high the cycle after an accept.
// While an earlier result is held by out_stall the update cycle waits, and in_stall
// stays high until that result leaves; out_stall never reaches in_stall directly.
// After reset and after every mode write the table is refilled with the mode's initial
// counter, one entry per cycle, during which in_stall stays high; configuration
// writes are still taken then.
module configurable_branch_predictor #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int HISTORY_MAX = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pc,
  input  logic        in_actual_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_prediction_correct,
  output logic        out_predicted_taken,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbp_pkg::*;

  localparam int          IW    = $clog2(TABLE_ENTRIES);
  localparam logic [31:0] TMASK = 32'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] FILL_LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {S_FILL, S_IDLE, S_UPD} state_t;

  state_t               state_r;
  logic [IW-1:0]        fill_cnt_r;
  mode_t                mode_r;
  logic [4:0]           hb_r;
  logic [HISTORY_MAX-1:0] hist_r;
  logic [IW-1:0]        idx_r;
  logic                 taken_r;
  logic                 out_valid_r;
  logic                 out_corr_r;
  logic                 out_pred_r;

  logic                 in_acc;
  logic                 upd_go;
  logic                 cfg_wr;
  logic [31:0]          pc_mix;
  logic [IW-1:0]        rd_idx;
  ctr_t                 rd_ctr;
  ctr_t                 ctr_nxt;
  logic                 pred;
  logic                 tbl_mode;
  logic [5:0]           hist_len;
  logic [HISTORY_MAX-1:0] hist_mask;
  logic [HISTORY_MAX-1:0] hist_nxt;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  ctr_t                 wr_data;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign upd_go   = !(out_valid_r && out_stall);

  assign pc_mix = (mode_r == MODE_GSHARE) ? (in_pc ^ 32'(hist_r)) : in_pc;
  assign rd_idx = IW'(pc_mix & TMASK);

  assign hist_len  = ({1'b0, hb_r} > 6'(HISTORY_MAX)) ? 6'(HISTORY_MAX) : {1'b0, hb_r};
  assign hist_mask = HISTORY_MAX'((33'd1 << hist_len) - 33'd1);
  assign hist_nxt  = HISTORY_MAX'({hist_r, taken_r}) & hist_mask;

  always_comb begin
    pred     = taken_r;
    ctr_nxt  = rd_ctr;
    tbl_mode = 1'b0;
    unique case (mode_r)
      MODE_NONE: pred = !taken_r;
      MODE_NT:   pred = 1'b0;
      MODE_T:    pred = 1'b1;
      MODE_ONE: begin
        tbl_mode = 1'b1;
        pred     = (rd_ctr == 2'd1);
        ctr_nxt  = {1'b0, taken_r};
      end
      MODE_TWO, MODE_GSHARE: begin
        tbl_mode = 1'b1;
        pred     = rd_ctr[1];
        if (taken_r) begin
          ctr_nxt = (rd_ctr == CTR_MAX) ? CTR_MAX : rd_ctr + 2'd1;
        end else begin
          ctr_nxt = (rd_ctr == CTR_MIN) ? CTR_MIN : rd_ctr - 2'd1;
        end
      end
      default:   pred = taken_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = ctr_nxt;
    if (state_r == S_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_cnt_r;
      wr_data = init_ctr(mode_r);
    end else if (state_r == S_UPD) begin
      wr_en = tbl_mode && upd_go;
    end
  end

  cbp_table #(
    .ENTRIES (TABLE_ENTRIES),
    .AW      (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_idx),
    .rd_data (rd_ctr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_cnt_r  <= '0;
      mode_r      <= MODE_RESET;
      hb_r        <= HB_RESET;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_FILL: begin
          fill_cnt_r <= fill_cnt_r + 1'b1;
          if (fill_cnt_r == FILL_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            idx_r   <= rd_idx;
            taken_r <= in_actual_taken;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            out_valid_r <= 1'b1;
            out_pred_r  <= pred;
            out_corr_r  <= (pred == taken_r);
            if (mode_r == MODE_GSHARE) begin
              hist_r <= hist_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_wr) begin
        if (paddr[2] == REG_MODE) begin
          mode_r     <= pwdata[2:0];
          state_r    <= S_FILL;
          fill_cnt_r <= '0;
          hist_r     <= '0;
        end else begin
          hb_r   <= pwdata[4:0];
          hist_r <= '0;
        end
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_HIST) begin
      prdata = 32'(hb_r);
    end else begin
      prdata = 32'(mode_r);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_prediction_correct = out_corr_r;
  assign out_predicted_taken    = out_pred_r;

endmodule

// File: hw/rtl/cbp_checker.sv
// port-level checker for the configurable branch predictor, bound to the top level
// depends on configurable_branch_predictor_macros.svh
`include "configurable_branch_predictor_macros.svh"

module cbp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_prediction_correct,
  input logic out_predicted_taken,
  input logic pready
);

  logic       in_acc;
  logic [1:0] out_bits;

  assign in_acc   = in_valid && !in_stall;
  assign out_bits = {out_prediction_correct, out_predicted_taken};

  // one item in flight at a time
  `CBP_ASSERT_NEXT(a_one_in_flight, in_acc, in_stall)
  // out_valid is checked after the accepted item passes its update state
  `CBP_ASSERT_NOW(a_result_latency, $past(in_acc, 2) && rst_n && $past(rst_n, 2), out_valid)
  // held result keeps its value
  `CBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bits))
  // apb port never waits
  `CBP_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind configurable_branch_predictor cbp_checker u_cbp_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_prediction_correct (out_prediction_correct),
  .out_predicted_taken    (out_predicted_taken),
  .pready                 (pready)
);

// File: test/configurable_branch_predictor_tb.sv
// self-checking bench for configurable_branch_predictor: resolved branches in, verdicts out
// depends on cbp_pkg and the predictor rtl; keeps its own counter table and history
`timescale 1ns / 1ps

module configurable_branch_predictor_tb;
  import cbp_pkg::*;

  localparam int TBL_N = 4096;
  localparam int HIST_MAX = 20;
  localparam int WD_LIMIT = 20000;
  localparam mode_t MODE_UNUSED = 3'd7;
  localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam logic [2:0] ADDR_HIST = {REG_HIST, 2'b00};

  typedef struct {
    logic [31:0] pc;
    logic        taken;
    int          gap;
  } branch_t;

  typedef struct packed {
    logic correct;
    logic taken;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pc = 32'd0;
  logic        in_actual_taken = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_prediction_correct;
  logic        out_predicted_taken;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  branch_t  branch_q[$];
  verdict_t verdict_q[$];

  ctr_t        ctr_tbl[TBL_N];
  logic [31:0] ghist;
  mode_t       cur_mode;
  logic [4:0]  hist_len;

  int errors = 0;
  int gap_left = 0;
  int hold_left = 0;
  int calm_left = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  configurable_branch_predictor dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pc(in_pc),
    .in_actual_taken(in_actual_taken),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_prediction_correct(out_prediction_correct),
    .out_predicted_taken(out_predicted_taken),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic refill_table();
    ctr_t v;
    case (cur_mode)
      MODE_ONE, MODE_GSHARE: v = 2'd1;
      MODE_TWO: v = 2'd2;
      default: v = 2'd0;
    endcase
    for (int i = 0; i < TBL_N; i++) ctr_tbl[i] = v;
    ghist = 32'd0;
  endtask

  function automatic ctr_t train(ctr_t c, logic taken);
    if (taken) return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
  endfunction

  task automatic predict_branch(input logic [31:0] pc, input logic taken, output logic pred);
    int unsigned idx;
    int n;
    logic [31:0] hmask;
    case (cur_mode)
      MODE_NONE: pred = ~taken;
      MODE_NT: pred = 1'b0;
      MODE_T: pred = 1'b1;
      MODE_ONE: begin
        idx = pc & (TBL_N - 1);
        pred = (ctr_tbl[idx] == 2'd1);
        ctr_tbl[idx] = {1'b0, taken};
      end
      MODE_TWO: begin
        idx = pc & (TBL_N - 1);
        pred = ctr_tbl[idx][1];
        ctr_tbl[idx] = train(ctr_tbl[idx], taken);
      end
      MODE_GSHARE: begin
        idx = (pc ^ ghist) & (TBL_N - 1);
        pred = ctr_tbl[idx][1];
        ctr_tbl[idx] = train(ctr_tbl[idx], taken);
        n = (hist_len > HIST_MAX) ? HIST_MAX : int'(hist_len);
        hmask = (32'h1 << n) - 32'h1;
        ghist = ((ghist << 1) | {31'd0, taken}) & hmask;
      end
      default: pred = taken;
    endcase
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic v;
    logic pred;
    v = in_valid;
    if (!rst_n) begin
      v = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_branch(branch_q[0].pc, branch_q[0].taken, pred);
        verdict_q.push_back('{correct: (pred == branch_q[0].taken), taken: pred});
        void'(branch_q.pop_front());
        v = 1'b0;
        if (branch_q.size() > 0) gap_left = branch_q[0].gap;
      end
      if (!v && branch_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          v = 1'b1;
          in_pc <= branch_q[0].pc;
          in_actual_taken <= branch_q[0].taken;
        end
      end
    end
    in_valid <= v;
  end

  // monitor
  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item correct %0b predicted %0b", $time,
                   out_prediction_correct, out_predicted_taken);
        end else begin
          want = verdict_q.pop_front();
          if (out_prediction_correct !== want.correct) begin
            errors++;
            $display("%0t: prediction_correct expected %0b actual %0b", $time,
                     want.correct, out_prediction_correct);
          end
          if (out_predicted_taken !== want.taken) begin
            errors++;
            $display("%0t: predicted_taken expected %0b actual %0b", $time,
                     want.taken, out_predicted_taken);
          end
        end
        if (calm_left > 0) begin
          calm_left--;
          hold_left = 0;
        end else begin
          if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
          hold_left = $urandom_range(0, 3);
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog, no progress", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MODE) begin
      cur_mode = data[2:0];
      refill_table();
    end else if (addr == ADDR_HIST) begin
      hist_len = data[4:0];
      ghist = 32'd0;
    end
  endtask

  // md or hb below zero leaves that register alone
  task automatic set_config(input int md, input int hb);
    logic [31:0] junk;
    bit hist_first;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    hist_first = $urandom_range(0, 1);
    if (hb >= 0 && hist_first) write_reg(ADDR_HIST, (junk & ~32'h1f) | hb);
    if (md >= 0) write_reg(ADDR_MODE, (junk & ~32'h7) | md);
    if (hb >= 0 && !hist_first) write_reg(ADDR_HIST, (junk & ~32'h1f) | hb);
  endtask

  task automatic push_branch(input logic [31:0] pc, input logic taken);
    int g;
    g = (quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 3);
    branch_q.push_back('{pc: pc, taken: taken, gap: g});
  endtask

  // biased hot branches with index-bit aliasing plus noise, or noise alone when hot is clear
  task automatic queue_random(input int n, input bit hot);
    logic [31:0] pool[8];
    int bias[8];
    int k;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 8; i++) begin
      pool[i] = $urandom;
      if (i >= 6) pool[i][11:0] = pool[i - 4][11:0];
      case ($urandom_range(0, 4))
        0: bias[i] = 0;
        1: bias[i] = 10;
        2: bias[i] = 50;
        3: bias[i] = 90;
        default: bias[i] = 100;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if (hot && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, 7);
        push_branch(pool[k], $urandom_range(0, 99) < bias[k]);
      end else begin
        push_branch($urandom, $urandom_range(0, 1));
      end
    end
  endtask

  task automatic settle();
    while (branch_q.size() != 0 || verdict_q.size() != 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    mode_t fixed_modes[4];
    fixed_modes = '{MODE_NONE, MODE_PERFECT, MODE_NT, MODE_T};
    cur_mode = MODE_RESET;
    hist_len = HB_RESET;
    refill_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_branch(32'h0000_0000, 1'b1);
    push_branch(32'h0000_0000, 1'b1);
    push_branch(32'hffff_ffff, 1'b0);
    push_branch(32'hffff_ffff, 1'b1);
    push_branch(32'h0000_0fff, 1'b1);
    push_branch(32'h0000_1000, 1'b0);
    push_branch(32'h8000_0000, 1'b1);
    push_branch(32'h7fff_ffff, 1'b0);
    push_branch(32'haaaa_aaaa, 1'b1);
    push_branch(32'h5555_5555, 1'b0);
    repeat (4) push_branch(32'h0000_0123, 1'b1);
    repeat (3) push_branch(32'h0000_0123, 1'b0);
    settle();

    set_config(MODE_UNUSED, 0);
    queue_random(40, 1'b0);
    settle();
    foreach (fixed_modes[i]) begin
      set_config(fixed_modes[i], $urandom_range(0, 31));
      queue_random(40, 1'b0);
      settle();
    end
    set_config(MODE_ONE, -1);
    queue_random(300, 1'b1);
    settle();
    set_config(MODE_TWO, 31);
    queue_random(300, 1'b1);
    settle();
    set_config(MODE_GSHARE, 0);
    queue_random(140, 1'b1);
    settle();
    set_config(-1, 1);
    queue_random(140, 1'b1);
    settle();
    set_config(-1, 20);
    queue_random(140, 1'b1);
    settle();
    set_config(-1, 31);
    queue_random(140, 1'b1);
    settle();
    set_config(-1, 21);
    queue_random(140, 1'b1);
    settle();
    set_config(-1, $urandom_range(2, 19));
    queue_random(140, 1'b1);
    settle();
    set_config(MODE_GSHARE, 12);
    queue_random(140, 1'b1);
    settle();

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
